@@ src/pwr_pkg.sv @@
// Package for the polar warp resampler: item type, fixed-point constants,
// arctangent table and register codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pwr_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int DIV_STEPS    = 32;
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [34:0]        TWO_PI_Q32  = 35'h6487ED511;

    localparam logic [8:0]  WIDTH_RESET  = 9'd256;
    localparam logic [8:0]  HEIGHT_RESET = 9'd256;
    localparam logic [7:0]  CX_RESET     = 8'd128;
    localparam logic [7:0]  CY_RESET     = 8'd128;
    localparam logic [8:0]  RMAX_RESET   = 9'd181;
    localparam logic [11:0] STEPS_RESET  = 12'd1137;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CX     = 2'd2;
    localparam logic [1:0] REG_CY     = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [15:0] pixel_in;
        logic [8:0]  radius;
        logic        ok;
    } t_item;

    typedef enum logic [3:0] {
        LIM_IDLE  = 4'b0001,
        LIM_SQ    = 4'b0010,
        LIM_ROOT  = 4'b0100,
        LIM_SCALE = 4'b1000
    } t_lim_state;

    function automatic logic [12:0] pwr_div_step(input logic [11:0] rem,
                                                 input logic [11:0] steps);
        logic [12:0] t;
        t = {rem, 1'b0};
        if (t >= {1'b0, steps}) begin
            return {1'b1, 12'(t - {1'b0, steps})};
        end
        return {1'b0, t[11:0]};
    endfunction

    function automatic logic signed [32:0] pwr_atan(input int idx);
        logic signed [32:0] v;
        case (idx)
            0: v = 33'sd536870912;
            1: v = 33'sd316933406;
            2: v = 33'sd167458907;
            3: v = 33'sd85004756;
            4: v = 33'sd42667331;
            5: v = 33'sd21354465;
            6: v = 33'sd10679838;
            7: v = 33'sd5340245;
            8: v = 33'sd2670163;
            9: v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41722;
            15: v = 33'sd20861;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2608;
            19: v = 33'sd1304;
            20: v = 33'sd652;
            21: v = 33'sd326;
            22: v = 33'sd163;
            23: v = 33'sd81;
            24: v = 33'sd41;
            25: v = 33'sd20;
            26: v = 33'sd10;
            27: v = 33'sd5;
            28: v = 33'sd3;
            29: v = 33'sd1;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ src/pwr_div.sv @@
// Pipelined restoring divider: angle phase = (step << 32) / steps.
// Depends on pwr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pwr_div import pwr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_item       i_item,
    input  wire logic [11:0] i_step,
    input  wire logic [11:0] i_steps,
    output logic             o_valid,
    output t_item            o_item,
    output logic [31:0]      o_phase
);
    logic [DIV_STEPS-1:0] r_v;
    t_item                r_it  [DIV_STEPS];
    logic [11:0]          r_rem [DIV_STEPS];
    logic [31:0]          r_q   [DIV_STEPS];
    logic [12:0]          w_st  [DIV_STEPS];

    always_comb begin
        w_st[0] = pwr_div_step(i_step, i_steps);
        for (int k = 1; k < DIV_STEPS; k++) begin
            w_st[k] = pwr_div_step(r_rem[k-1], i_steps);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it[0]  <= i_item;
            r_rem[0] <= w_st[0][11:0];
            r_q[0]   <= {31'd0, w_st[0][12]};
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_it[k]  <= r_it[k-1];
                r_rem[k] <= w_st[k][11:0];
                r_q[k]   <= {r_q[k-1][30:0], w_st[k][12]};
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_item  = r_it[DIV_STEPS-1];
    assign o_phase = r_q[DIV_STEPS-1];
endmodule
`default_nettype wire

@@ src/pwr_cordic.sv @@
// Pipelined rotation-mode CORDIC giving cos and sin in Q30 of a Q32 turn phase.
// Depends on pwr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pwr_cordic import pwr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_item       i_item,
    input  wire logic [31:0] i_phase,
    output logic             o_valid,
    output t_item            o_item,
    output logic signed [32:0] o_cos,
    output logic signed [32:0] o_sin
);
    logic [CORDIC_STEPS-1:0] r_v;
    t_item              r_it [CORDIC_STEPS];
    logic [1:0]         r_qd [CORDIC_STEPS];
    logic signed [32:0] r_x  [CORDIC_STEPS];
    logic signed [32:0] r_y  [CORDIC_STEPS];
    logic signed [32:0] r_z  [CORDIC_STEPS];
    logic signed [32:0] w_x  [CORDIC_STEPS];
    logic signed [32:0] w_y  [CORDIC_STEPS];
    logic signed [32:0] w_z  [CORDIC_STEPS];

    always_comb begin
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (k == 0) begin
                w_x[k] = CORDIC_GAIN;
                w_y[k] = '0;
                w_z[k] = $signed({3'b000, i_phase[29:0]});
            end else begin
                w_x[k] = r_x[k-1];
                w_y[k] = r_y[k-1];
                w_z[k] = r_z[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[CORDIC_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it[0] <= i_item;
            r_qd[0] <= i_phase[31:30];
            for (int k = 1; k < CORDIC_STEPS; k++) begin
                r_it[k] <= r_it[k-1];
                r_qd[k] <= r_qd[k-1];
            end
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                if (!w_z[k][32]) begin
                    r_x[k] <= w_x[k] - (w_y[k] >>> k);
                    r_y[k] <= w_y[k] + (w_x[k] >>> k);
                    r_z[k] <= w_z[k] - pwr_atan(k);
                end else begin
                    r_x[k] <= w_x[k] + (w_y[k] >>> k);
                    r_y[k] <= w_y[k] - (w_x[k] >>> k);
                    r_z[k] <= w_z[k] + pwr_atan(k);
                end
            end
        end
    end

    always_comb begin
        case (r_qd[CORDIC_STEPS-1])
            2'd0: begin
                o_cos = r_x[CORDIC_STEPS-1];
                o_sin = r_y[CORDIC_STEPS-1];
            end
            2'd1: begin
                o_cos = -r_y[CORDIC_STEPS-1];
                o_sin = r_x[CORDIC_STEPS-1];
            end
            2'd2: begin
                o_cos = -r_x[CORDIC_STEPS-1];
                o_sin = -r_y[CORDIC_STEPS-1];
            end
            default: begin
                o_cos = r_y[CORDIC_STEPS-1];
                o_sin = -r_x[CORDIC_STEPS-1];
            end
        endcase
    end

    assign o_valid = r_v[CORDIC_STEPS-1];
    assign o_item  = r_it[CORDIC_STEPS-1];
endmodule
`default_nettype wire

@@ src/pwr_store.sv @@
// Source point scaling, bounds check and pixel store with the output register.
// Depends on pwr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pwr_store import pwr_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire t_item             i_item,
    input  wire logic signed [32:0] i_cos,
    input  wire logic signed [32:0] i_sin,
    input  wire logic [8:0]        i_width,
    input  wire logic [8:0]        i_height,
    input  wire logic [7:0]        i_cx,
    input  wire logic [7:0]        i_cy,
    output logic                   o_valid,
    output logic [15:0]            o_pixel,
    output logic                   o_hit
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [PIXEL_BITS-1:0] mem [DEPTH];

    logic               r_pv;
    t_item              r_pit;
    logic signed [42:0] r_px;
    logic signed [42:0] r_py;
    logic               r_v;
    logic               r_hit;
    logic [PIXEL_BITS-1:0] r_rdata;

    logic signed [43:0] w_sumx, w_sumy;
    logic signed [13:0] w_sx, w_sy;
    logic               w_in, w_wr_ok;
    logic [AW-1:0]      w_raddr, w_waddr;

    always_comb begin
        w_sumx = 44'(r_px) + $signed({6'd0, i_cx, 30'd0}) + 44'sd536870912;
        w_sumy = 44'(r_py) + $signed({6'd0, i_cy, 30'd0}) + 44'sd536870912;
        w_sx = w_sumx[43:30];
        w_sy = w_sumy[43:30];
        w_in = !w_sx[13] && !w_sy[13]
            && (w_sx[12:0] < {4'd0, i_width}) && (w_sy[12:0] < {4'd0, i_height})
            && (32'(w_sx[12:0]) < MAX_WIDTH) && (32'(w_sy[12:0]) < MAX_HEIGHT);
        w_raddr = AW'(32'(w_sy[12:0]) * MAX_WIDTH + 32'(w_sx[12:0]));
        w_waddr = AW'(32'(r_pit.pos_y) * MAX_WIDTH + 32'(r_pit.pos_x));
        w_wr_ok = (32'(r_pit.pos_x) < MAX_WIDTH) && (32'(r_pit.pos_y) < MAX_HEIGHT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_v  <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
            r_v  <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pit <= i_item;
            r_px  <= $signed({1'b0, i_item.radius}) * i_cos;
            r_py  <= $signed({1'b0, i_item.radius}) * i_sin;
            r_hit <= r_pit.kind && r_pit.ok && w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_pv && !r_pit.kind && w_wr_ok) begin
                mem[w_waddr] <= PIXEL_BITS'(r_pit.pixel_in);
            end
            r_rdata <= mem[w_raddr];
        end
    end

    assign o_valid = r_v;
    assign o_hit   = r_hit;
    assign o_pixel = r_hit ? 16'(r_rdata) : 16'd0;
endmodule
`default_nettype wire

@@ src/polar_warp_resampler_unit.sv @@
// Top level of the polar warp resampler: register port, limit unit, pipeline.
// Depends on pwr_pkg, pwr_div, pwr_cordic, pwr_store.
//
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   kind, pos, pixel_in, radius, angle_step
// output    out        o_out_valid / i_out_stall pixel_out, hit, request_ok, limits
// config    in         APB psel/penable/pwrite   image size, centre
//
// One beat per cycle unless stalled; pipeline of 32 divider, 30 CORDIC, product and store stages.
// A register write recomputes the limits (square, root, scale states); input is stalled then.
// The whole pipeline holds while the output beat waits under stall.
// Synchronous active-low reset clears valids and restores reset limits.
`timescale 1ns / 1ps
`default_nettype none
module polar_warp_resampler_unit import pwr_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_pos_x,
    input  wire logic [7:0]  i_pos_y,
    input  wire logic [15:0] i_pixel_in,
    input  wire logic [8:0]  i_radius,
    input  wire logic [11:0] i_angle_step,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_pixel_out,
    output logic             o_hit,
    output logic             o_request_ok,
    output logic [8:0]       o_radius_limit,
    output logic [11:0]      o_angle_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [8:0]  r_width, r_height;
    logic [7:0]  r_cx, r_cy;
    logic [8:0]  r_rmax;
    logic [11:0] r_steps;
    t_lim_state  r_state;
    logic [19:0] r_val, r_root, r_bit;

    logic  w_wr, w_busy, w_en, w_acc;
    t_item w_item, w_ditem, w_citem;
    logic  w_dvalid, w_cvalid;
    logic [31:0] w_phase;
    logic signed [32:0] w_cos, w_sin;
    logic [17:0] w_ax, w_bx, w_ay, w_by;
    logic signed [9:0] w_dx1, w_dy1;
    logic [19:0] w_trial;
    logic [9:0]  w_sat;
    logic [44:0] w_prod;
    logic        r_ok_out [2];

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_busy = (r_state != LIM_IDLE);

    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {23'd0, r_width};
            REG_HEIGHT: prdata = {23'd0, r_height};
            REG_CX:     prdata = {24'd0, r_cx};
            REG_CY:     prdata = {24'd0, r_cy};
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        w_dx1 = $signed({1'b0, r_width}) - $signed({2'b00, r_cx});
        w_dy1 = $signed({1'b0, r_height}) - $signed({2'b00, r_cy});
        w_ax = 18'({r_cx} * {r_cx});
        w_ay = 18'({r_cy} * {r_cy});
        w_bx = 18'(w_dx1 * w_dx1);
        w_by = 18'(w_dy1 * w_dy1);
        w_trial = r_root + r_bit;
        w_sat = (r_root > 20'd511) ? 10'd511 : r_root[9:0];
        w_prod = 45'(w_sat) * 45'(TWO_PI_Q32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_cx     <= CX_RESET;
            r_cy     <= CY_RESET;
            r_rmax   <= RMAX_RESET;
            r_steps  <= STEPS_RESET;
            r_state  <= LIM_IDLE;
        end else begin
            if (w_wr) begin
                unique case (paddr[3:2])
                    REG_WIDTH:  r_width  <= pwdata[8:0];
                    REG_HEIGHT: r_height <= pwdata[8:0];
                    REG_CX:     r_cx     <= pwdata[7:0];
                    REG_CY:     r_cy     <= pwdata[7:0];
                    default:    r_cx     <= r_cx;
                endcase
                r_state <= LIM_SQ;
            end else begin
                unique case (r_state)
                    LIM_IDLE: r_state <= LIM_IDLE;
                    LIM_SQ: begin
                        r_val   <= 20'((w_ax > w_bx ? w_ax : w_bx))
                                 + 20'((w_ay > w_by ? w_ay : w_by));
                        r_root  <= '0;
                        r_bit   <= 20'h40000;
                        r_state <= LIM_ROOT;
                    end
                    LIM_ROOT: begin
                        if (r_val >= w_trial) begin
                            r_val  <= r_val - w_trial;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                        if (r_bit[0]) begin
                            r_state <= LIM_SCALE;
                        end
                    end
                    LIM_SCALE: begin
                        r_rmax  <= w_sat[8:0];
                        r_steps <= w_prod[43:32];
                        r_state <= LIM_IDLE;
                    end
                    default: r_state <= LIM_IDLE;
                endcase
            end
        end
    end

    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = w_busy || !w_en;
    assign w_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        w_item.kind     = i_kind;
        w_item.pos_x    = i_pos_x;
        w_item.pos_y    = i_pos_y;
        w_item.pixel_in = i_pixel_in;
        w_item.radius   = i_radius;
        w_item.ok       = i_kind && (i_radius < r_rmax) && (i_angle_step < r_steps);
    end

    pwr_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_acc),
        .i_item(w_item), .i_step(i_angle_step), .i_steps(r_steps),
        .o_valid(w_dvalid), .o_item(w_ditem), .o_phase(w_phase)
    );

    pwr_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_dvalid),
        .i_item(w_ditem), .i_phase(w_phase),
        .o_valid(w_cvalid), .o_item(w_citem), .o_cos(w_cos), .o_sin(w_sin)
    );

    pwr_store #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PIXEL_BITS(PIXEL_BITS)
    ) u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_cvalid),
        .i_item(w_citem), .i_cos(w_cos), .i_sin(w_sin),
        .i_width(r_width), .i_height(r_height), .i_cx(r_cx), .i_cy(r_cy),
        .o_valid(o_out_valid), .o_pixel(o_pixel_out), .o_hit(o_hit)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ok_out[0] <= w_citem.ok;
            r_ok_out[1] <= r_ok_out[0];
        end
    end

    assign o_request_ok   = r_ok_out[1];
    assign o_radius_limit = r_rmax;
    assign o_angle_count  = r_steps;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> (r_state == LIM_IDLE))
        else $error("item accepted while limits recompute");
    a_hit_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> o_request_ok)
        else $error("hit without a valid request");
    a_write_starts_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> (r_state == LIM_SQ))
        else $error("register write did not restart limit unit");
`endif
endmodule
`default_nettype wire
